// ===== rtl/dast_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dast_pkg
// Shared types and constants for the daily alarm slot table: request and
// response items, the stored entry layout, mode and status codes.
// ----------------------------------------------------------------------------
package dast_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W      = 4;
    localparam int CMP_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Time arithmetic.
    localparam int TOD_W        = 11;
    localparam int LAST_HOUR    = 23;
    localparam int LAST_MINUTE  = 59;
    localparam int TICK_W       = 12;
    localparam int PUMP_W       = 32;

    // Operation codes carried in the mode field.
    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_ADD       = 4'd1;
    localparam logic [3:0] MODE_OVERWRITE = 4'd2;
    localparam logic [3:0] MODE_TRIGGER   = 4'd3;
    localparam logic [3:0] MODE_SET_ACT   = 4'd4;
    localparam logic [3:0] MODE_SET_PEND  = 4'd5;
    localparam logic [3:0] MODE_ALL_PEND  = 4'd6;
    localparam logic [3:0] MODE_RST_TIME  = 4'd7;
    localparam logic [3:0] MODE_QUERY     = 4'd8;

    // Status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_USED = 2'd2;

    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] slot;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic [7:0] action_code;
        logic       flag_value;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic       pump_on;
    } req_item_t;

    typedef struct packed {
        logic        fired;
        logic [3:0]  fired_slot;
        logic [7:0]  fired_action;
        logic [1:0]  status;
        logic        active_flag;
        logic [31:0] pump_seconds;
    } rsp_item_t;

    // One stored alarm entry, 22 bits.
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       time_ok;
        logic       pending;
        logic       active;
        logic [7:0] action;
    } entry_t;

endpackage

// ===== rtl/dast_time_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dast_time_match
// Decides whether a stored entry fires on a tick: it must be pending, active
// and time-valid, and its minute of day must equal the current one.
// ----------------------------------------------------------------------------
module dast_time_match (
    input  dast_pkg::entry_t   entry,
    input  logic [4:0]         now_hour,
    input  logic [5:0]         now_minute,
    output logic               match
);

    logic [dast_pkg::TOD_W-1:0] entry_tod;
    logic [dast_pkg::TOD_W-1:0] now_tod;

    // Minute of day as hour*64 - hour*4 + minute; raw fields, no range check.
    assign entry_tod = {entry.hour, 6'b000000} - {4'b0000, entry.hour, 2'b00}
                     + {5'b00000, entry.minute};
    assign now_tod   = {now_hour, 6'b000000} - {4'b0000, now_hour, 2'b00}
                     + {5'b00000, now_minute};

    assign match = entry.pending && entry.active && entry.time_ok
                && (entry_tod == now_tod);

endmodule

// ===== rtl/daily_alarm_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_alarm_slot_table
// Request transfer to response valid: add, overwrite, reset time, undefined
// modes and rejected slots go straight to ST_PUSH; trigger, set and query read
// the slot in ST_MOD first; tick and set-all-pending step through the entries
// in ST_SCAN or ST_SWEEP (one entry per cycle) first. Throughput: one request
// at a time; the next is accepted after ST_PUSH, which waits out a stalled response.
// Reset clears control state, entry count and pump counter, sets tick_seconds to 1.
// ----------------------------------------------------------------------------
module daily_alarm_slot_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  dast_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output dast_pkg::rsp_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [11:0]         cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_PUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    dast_pkg::req_item_t           item_reg, item_next;
    dast_pkg::rsp_item_t           res_reg, res_next;
    dast_pkg::rsp_item_t           rsp_reg, rsp_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [dast_pkg::CMP_W-1:0]    idx_reg, idx_next;
    logic [dast_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [dast_pkg::PUMP_W-1:0]   pump_reg, pump_next;
    logic [dast_pkg::TICK_W-1:0]   tick_reg, tick_next;

    // Entry RAM with registered read data.
    dast_pkg::entry_t              entry_mem [dast_pkg::MAX_ENTRIES];
    dast_pkg::entry_t              rd_data_reg;
    dast_pkg::entry_t              wr_data;
    logic                          wr_en;
    logic [dast_pkg::CMP_W-1:0]    wr_addr;
    logic                          rd_en;
    logic [dast_pkg::CMP_W-1:0]    rd_addr;

    logic                          req_xfer;
    logic                          rsp_xfer;
    logic                          in_use;
    logic                          time_hit;
    logic                          new_time_ok;
    logic [dast_pkg::CMP_W-1:0]    slot_ext;
    logic [dast_pkg::CMP_W-1:0]    count_ext;
    logic [dast_pkg::CMP_W-1:0]    idx_inc;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slot_ext  = dast_pkg::CMP_W'(req.slot);
    assign count_ext = dast_pkg::CMP_W'(count_reg);
    assign in_use    = slot_ext < count_ext;
    assign idx_inc   = idx_reg + dast_pkg::CMP_W'(1);

    assign new_time_ok = (req.entry_hour <= 5'(dast_pkg::LAST_HOUR))
                      && (req.entry_minute <= 6'(dast_pkg::LAST_MINUTE));

    // Tick match on the entry just read during a scan.
    dast_time_match u_match (
        .entry      (rd_data_reg),
        .now_hour   (item_reg.now_hour),
        .now_minute (item_reg.now_minute),
        .match      (time_hit)
    );

    // Sequencer: decode on transfer, then read, scan or sweep the RAM.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pump_next      = pump_reg;
        tick_next      = tick_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_ext;
        wr_data        = rd_data_reg;
        rd_en          = 1'b0;
        rd_addr        = slot_ext;

        if (cfg_valid && cfg_ready)
        begin
            tick_next = cfg_data;
        end

        if (rsp_xfer)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    item_next  = req;
                    res_next   = '0;
                    idx_next   = '0;
                    state_next = ST_PUSH;
                    unique case (req.mode) inside
                        dast_pkg::MODE_TICK:
                        begin
                            if (req.pump_on)
                            begin
                                pump_next = pump_reg
                                          + dast_pkg::PUMP_W'(tick_reg);
                            end
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        dast_pkg::MODE_ADD:
                        begin
                            if (count_reg == dast_pkg::CNT_W'(dast_pkg::MAX_ENTRIES))
                            begin
                                res_next.status = dast_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = count_ext;
                                wr_data.hour    = req.entry_hour;
                                wr_data.minute  = req.entry_minute;
                                wr_data.time_ok = 1'b1;
                                wr_data.pending = 1'b1;
                                wr_data.active  = 1'b1;
                                wr_data.action  = req.action_code;
                                count_next      = count_reg + dast_pkg::CNT_W'(1);
                            end
                        end
                        dast_pkg::MODE_OVERWRITE:
                        begin
                            if (!in_use)
                            begin
                                res_next.status = dast_pkg::STATUS_NOT_USED;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_data.hour    = new_time_ok ? req.entry_hour : '0;
                                wr_data.minute  = new_time_ok ? req.entry_minute : '0;
                                wr_data.time_ok = new_time_ok;
                                wr_data.pending = 1'b1;
                                wr_data.active  = 1'b1;
                                wr_data.action  = req.action_code;
                            end
                        end
                        dast_pkg::MODE_TRIGGER, dast_pkg::MODE_SET_ACT,
                        dast_pkg::MODE_SET_PEND, dast_pkg::MODE_QUERY:
                        begin
                            if (!in_use)
                            begin
                                res_next.status = dast_pkg::STATUS_NOT_USED;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_MOD;
                            end
                        end
                        dast_pkg::MODE_ALL_PEND:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SWEEP;
                            end
                        end
                        dast_pkg::MODE_RST_TIME:
                        begin
                            pump_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Read data of the addressed slot is valid here.
            ST_MOD:
            begin
                wr_addr    = dast_pkg::CMP_W'(item_reg.slot);
                state_next = ST_PUSH;
                unique case (item_reg.mode)
                    dast_pkg::MODE_TRIGGER:
                    begin
                        res_next.fired        = 1'b1;
                        res_next.fired_slot   = item_reg.slot;
                        res_next.fired_action = rd_data_reg.action;
                    end
                    dast_pkg::MODE_SET_ACT:
                    begin
                        wr_en          = 1'b1;
                        wr_data.active = item_reg.flag_value;
                    end
                    dast_pkg::MODE_SET_PEND:
                    begin
                        wr_en           = 1'b1;
                        wr_data.pending = item_reg.flag_value;
                    end
                    default:
                    begin
                        res_next.active_flag = rd_data_reg.active;
                    end
                endcase
            end

            // One entry per cycle; the first match fires and stops the scan.
            ST_SCAN:
            begin
                wr_addr = idx_reg;
                if (time_hit)
                begin
                    wr_en                 = 1'b1;
                    wr_data.pending       = 1'b0;
                    res_next.fired        = 1'b1;
                    res_next.fired_slot   = idx_reg[3:0];
                    res_next.fired_action = rd_data_reg.action;
                    state_next            = ST_PUSH;
                end
                else if (idx_inc == count_ext)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end

            // Read the next entry while writing back the current one.
            ST_SWEEP:
            begin
                wr_en           = 1'b1;
                wr_addr         = idx_reg;
                wr_data.pending = 1'b1;
                if (idx_inc == count_ext)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end

            // Hand the result to the response register once it is free.
            ST_PUSH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next              = res_reg;
                    rsp_next.pump_seconds = pump_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            pump_reg      <= '0;
            tick_reg      <= dast_pkg::TICK_W'(1);
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            pump_reg      <= pump_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    // Entry RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr[dast_pkg::IDX_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr[dast_pkg::IDX_W-1:0]];
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Daily alarm slot table testbench
// Drives request transfers into daily_alarm_slot_table and checks every
// response against an in-bench model of the alarm table, the entry count and
// the pump-on counter. A short directed run covers the corner cases. Random
// phases follow under several tick_seconds settings, with random idling on
// both channels and one long response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import dast_pkg::*;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int MINUTES_PER_DAY  = 24 * MINUTES_PER_HOUR;
    localparam int BLOCK_LATENCY    = MAX_ENTRIES + 2;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASE_ITEMS      = 260;
    localparam int NUM_PHASES       = 5;
    localparam int REPORT_LIMIT     = 10;
    localparam logic [3:0] MODE_UNDEF_FIRST = MODE_QUERY + 4'd1;
    localparam logic [3:0] MODE_UNDEF_LAST  = 4'hF;

    // Model of the alarm table; it predicts one response per request
    // transfer and checks the responses in order.
    class alarm_table_tracker;
        entry_t            slots [MAX_ENTRIES];
        int                used_count;
        logic [PUMP_W-1:0] pump_total;
        logic [TICK_W-1:0] tick_step;
        rsp_item_t         awaited_rsp [$];
        int                mismatch_count;

        function new();
            used_count     = 0;
            pump_total     = '0;
            tick_step      = 1;
            mismatch_count = 0;
            foreach (slots[k])
                slots[k] = '0;
        endfunction

        function void set_tick_step(input logic [TICK_W-1:0] value);
            tick_step = value;
        endfunction

        function void note_request(input req_item_t item);
            rsp_item_t reply;
            int        now_tod;
            int        entry_tod;
            int        i;
            bit        in_use;
            bit        found;
            reply  = '0;
            in_use = int'(item.slot) < used_count;
            found  = 1'b0;
            case (item.mode)
                MODE_TICK:
                begin
                    now_tod = int'(item.now_hour) * MINUTES_PER_HOUR + int'(item.now_minute);
                    if (item.pump_on)
                        pump_total = pump_total + PUMP_W'(tick_step);
                    for (i = 0; i < used_count && !found; i++)
                    begin
                        entry_tod = int'(slots[i].hour) * MINUTES_PER_HOUR
                                  + int'(slots[i].minute);
                        if (slots[i].pending && slots[i].active && slots[i].time_ok &&
                            entry_tod == now_tod)
                        begin
                            slots[i].pending   = 1'b0;
                            found              = 1'b1;
                            reply.fired        = 1'b1;
                            reply.fired_slot   = 4'(i);
                            reply.fired_action = slots[i].action;
                        end
                    end
                end
                MODE_ADD:
                begin
                    if (used_count >= MAX_ENTRIES)
                        reply.status = STATUS_FULL;
                    else
                    begin
                        slots[used_count].hour    = item.entry_hour;
                        slots[used_count].minute  = item.entry_minute;
                        slots[used_count].time_ok = 1'b1;
                        slots[used_count].pending = 1'b1;
                        slots[used_count].active  = 1'b1;
                        slots[used_count].action  = item.action_code;
                        used_count++;
                    end
                end
                MODE_OVERWRITE:
                begin
                    if (!in_use)
                        reply.status = STATUS_NOT_USED;
                    else
                    begin
                        found = item.entry_hour <= LAST_HOUR && item.entry_minute <= LAST_MINUTE;
                        slots[item.slot].hour    = found ? item.entry_hour : '0;
                        slots[item.slot].minute  = found ? item.entry_minute : '0;
                        slots[item.slot].time_ok = found;
                        slots[item.slot].pending = 1'b1;
                        slots[item.slot].active  = 1'b1;
                        slots[item.slot].action  = item.action_code;
                    end
                end
                MODE_TRIGGER:
                begin
                    if (!in_use)
                        reply.status = STATUS_NOT_USED;
                    else
                    begin
                        reply.fired        = 1'b1;
                        reply.fired_slot   = item.slot;
                        reply.fired_action = slots[item.slot].action;
                    end
                end
                MODE_SET_ACT:
                begin
                    if (!in_use)
                        reply.status = STATUS_NOT_USED;
                    else
                        slots[item.slot].active = item.flag_value;
                end
                MODE_SET_PEND:
                begin
                    if (!in_use)
                        reply.status = STATUS_NOT_USED;
                    else
                        slots[item.slot].pending = item.flag_value;
                end
                MODE_ALL_PEND:
                begin
                    for (i = 0; i < used_count; i++)
                        slots[i].pending = 1'b1;
                end
                MODE_RST_TIME:
                begin
                    pump_total = '0;
                end
                MODE_QUERY:
                begin
                    if (!in_use)
                        reply.status = STATUS_NOT_USED;
                    else
                        reply.active_flag = slots[item.slot].active;
                end
                default:
                begin
                end
            endcase
            reply.pump_seconds = pump_total;
            awaited_rsp.push_back(reply);
        endfunction

        function void check_response(input rsp_item_t actual);
            rsp_item_t want;
            if (awaited_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected response: fired=%0d slot=%0d action=%0h status=%0d",
                             actual.fired, actual.fired_slot, actual.fired_action,
                             actual.status);
                return;
            end
            want = awaited_rsp.pop_front();
            if (actual.fired !== want.fired || actual.fired_slot !== want.fired_slot ||
                actual.fired_action !== want.fired_action || actual.status !== want.status ||
                actual.active_flag !== want.active_flag ||
                actual.pump_seconds !== want.pump_seconds)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("Mismatch expected: fired=%0d slot=%0d action=%0h status=%0d act=%0d pump=%0d",
                             want.fired, want.fired_slot, want.fired_action, want.status,
                             want.active_flag, want.pump_seconds);
                    $display("         actual:   fired=%0d slot=%0d action=%0h status=%0d act=%0d pump=%0d",
                             actual.fired, actual.fired_slot, actual.fired_action,
                             actual.status, actual.active_flag, actual.pump_seconds);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_item_t   req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_item_t   rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    alarm_table_tracker sb = new();

    bit quiet;
    bit long_hold_req;
    int send_stretch;
    bit send_idles;
    int cycle_count;

    daily_alarm_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with a run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Response monitor: every response transfer is checked in order.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // Response side: random stall bursts, calm stretches and one long hold-off.
    initial
    begin
        int burst;
        int stretch;
        bit stalls_on;
        rsp_stall = 1'b0;
        stretch   = 0;
        stalls_on = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                stretch   = $urandom_range(20, 80);
                stalls_on = $urandom_range(0, 2) != 0;
            end
            stretch--;
            if (long_hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet && stalls_on && $urandom_range(0, 99) < 20)
            begin
                burst = $urandom_range(1, 9);
                rsp_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Offers one request and waits for its transfer; idles first at random.
    task automatic send_request(input req_item_t item);
        int gap;
        if (send_stretch == 0)
        begin
            send_stretch = $urandom_range(20, 80);
            send_idles   = $urandom_range(0, 2) != 0;
        end
        send_stretch--;
        if (!quiet && send_idles && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
    endtask

    // Stops offering requests and waits until the block has drained.
    task automatic drain_block();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (BLOCK_LATENCY) @(posedge clk);
    endtask

    // Writes tick_seconds through the configuration channel.
    task automatic write_tick_step(input logic [TICK_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_tick_step(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_item_t build_request(input logic [3:0] mode, input int slot,
                                                input int hour, input int minute,
                                                input int code, input bit flag,
                                                input int now_h, input int now_m,
                                                input bit pump);
        req_item_t item;
        item.mode         = mode;
        item.slot         = 4'(slot);
        item.entry_hour   = 5'(hour);
        item.entry_minute = 6'(minute);
        item.action_code  = 8'(code);
        item.flag_value   = flag;
        item.now_hour     = 5'(now_h);
        item.now_minute   = 6'(now_m);
        item.pump_on      = pump;
        return item;
    endfunction

    function automatic logic [3:0] pick_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return MODE_TICK;
        else if (roll < 43)
            return MODE_ADD;
        else if (roll < 53)
            return MODE_OVERWRITE;
        else if (roll < 61)
            return MODE_TRIGGER;
        else if (roll < 69)
            return MODE_SET_ACT;
        else if (roll < 77)
            return MODE_SET_PEND;
        else if (roll < 83)
            return MODE_ALL_PEND;
        else if (roll < 86)
            return MODE_RST_TIME;
        else if (roll < 94)
            return MODE_QUERY;
        else
            return 4'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
    endfunction

    // Random request; slots mostly in use, ticks often aimed at a stored time.
    function automatic req_item_t make_request(input logic [3:0] mode);
        req_item_t item;
        int        pick;
        int        tod;
        item = build_request(mode, $urandom_range(0, 15), $urandom_range(0, 31),
                             $urandom_range(0, 63), $urandom_range(0, 255),
                             1'($urandom_range(0, 1)), $urandom_range(0, LAST_HOUR),
                             $urandom_range(0, LAST_MINUTE), 1'($urandom_range(0, 1)));
        if (sb.used_count != 0 && $urandom_range(0, 99) < 85)
            item.slot = 4'($urandom_range(0, sb.used_count - 1));
        if ((mode == MODE_ADD || mode == MODE_OVERWRITE) && $urandom_range(0, 99) < 80)
        begin
            item.entry_hour   = 5'($urandom_range(0, LAST_HOUR));
            item.entry_minute = 6'($urandom_range(0, LAST_MINUTE));
        end
        if (mode == MODE_SET_ACT && $urandom_range(0, 99) < 75)
            item.flag_value = 1'b1;
        if (mode == MODE_TICK && sb.used_count != 0 && $urandom_range(0, 99) < 70)
        begin
            pick = $urandom_range(0, sb.used_count - 1);
            tod  = int'(sb.slots[pick].hour) * MINUTES_PER_HOUR + int'(sb.slots[pick].minute);
            if (tod < MINUTES_PER_DAY)
            begin
                item.now_hour   = 5'(tod / MINUTES_PER_HOUR);
                item.now_minute = 6'(tod % MINUTES_PER_HOUR);
            end
        end
        return item;
    endfunction

    // Main sequence: reset, directed corner cases, then random phases.
    initial
    begin
        logic [TICK_W-1:0] tick_values [NUM_PHASES];
        int phase;
        int n;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        quiet        = 1'b0;
        send_stretch = 0;
        send_idles   = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: tick without match and slots not in use.
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1));
        send_request(build_request(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(build_request(MODE_TRIGGER, 15, 31, 63, 255, 1, 23, 59, 1));
        send_request(build_request(MODE_OVERWRITE, 0, 5, 5, 8'h11, 0, 0, 0, 0));
        send_request(build_request(MODE_SET_ACT, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(build_request(MODE_SET_PEND, 3, 0, 0, 0, 1, 0, 0, 0));
        // Raw add times: minute sixty of hour zero equals one o'clock.
        send_request(build_request(MODE_ADD, 0, 0, 60, 8'hFF, 0, 0, 0, 0));
        send_request(build_request(MODE_ADD, 0, 31, 63, 8'h00, 1, 0, 0, 0));
        send_request(build_request(MODE_ADD, 0, 1, 0, 8'hA5, 0, 0, 0, 0));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 1, 0, 1));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 1, 0, 1));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 1, 0, 1));
        send_request(build_request(MODE_TRIGGER, 1, 0, 0, 0, 0, 0, 0, 0));
        // Overwrites with an hour or a minute out of range mark the time invalid.
        send_request(build_request(MODE_OVERWRITE, 1, 24, 0, 8'h5A, 0, 0, 0, 0));
        send_request(build_request(MODE_OVERWRITE, 2, 23, 60, 8'h81, 0, 0, 0, 0));
        send_request(build_request(MODE_OVERWRITE, 0, 23, 59, 8'h3C, 0, 0, 0, 0));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 23, 59, 0));
        // An inactive entry does not fire even when pending.
        send_request(build_request(MODE_SET_ACT, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(build_request(MODE_SET_PEND, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 23, 59, 1));
        send_request(build_request(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(build_request(MODE_SET_ACT, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(build_request(MODE_TICK, 0, 0, 0, 0, 0, 23, 59, 1));
        send_request(build_request(MODE_ALL_PEND, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(build_request(MODE_RST_TIME, 0, 0, 0, 0, 0, 0, 0, 1));
        send_request(build_request(MODE_UNDEF_LAST, 2, 31, 63, 255, 1, 23, 59, 1));

        // Random phases, each under its own tick_seconds setting.
        tick_values[0] = '0;
        tick_values[1] = 12'd3600;
        tick_values[2] = TICK_W'($urandom_range(1, 3599));
        tick_values[3] = 12'd1;
        tick_values[4] = TICK_W'($urandom_range(1, 3599));
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_block();
            write_tick_step(tick_values[phase]);
            if (phase == NUM_PHASES - 1)
                quiet = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 40)
                    long_hold_req = 1'b1;
                send_request(make_request(pick_mode()));
            end
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Wait for the last responses, then report.
        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (4 * BLOCK_LATENCY) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.awaited_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
